>>> hdl/ndpt_pkg.sv
// Package of the neuron dot-product and tanh core: widths, fixed-point
// constants, request codes and the sequencer state type.
// Depends on nothing; used by neuron_dot_product_tanh_core.
package ndpt_pkg;

    localparam int MAX_INPUTS = 64;
    localparam int WADDR_W    = $clog2(MAX_INPUTS);

    localparam int IDX_W  = 6;
    localparam int VAL_W  = 16;
    localparam int CNT_W  = 7;
    localparam int PROD_W = 2 * VAL_W;
    localparam int ACC_W  = 48;

    // Unsigned Q1.60 fixed point used by the tanh evaluation.
    localparam int FRAC   = 60;
    localparam int FX_W   = FRAC + 1;
    localparam int MP_W   = 2 * FX_W - 1;
    localparam int U_W    = 56;
    localparam int HALF_W = 32;
    localparam int QUO_W  = 16;
    localparam int STEP_W = 6;
    localparam int KCNT_W = 4;

    localparam int N_TERMS   = 12;
    localparam int N_SQUARES = 9;
    localparam int MUL_LAST  = 4;
    localparam int DIV_LAST  = FX_W - 1;
    localparam int QUO_LAST  = QUO_W - 1;

    localparam logic [FX_W-1:0] Q60_ONE = FX_W'(1) << FRAC;

    localparam logic REQ_WEIGHT = 1'b0;
    localparam logic REQ_DATA   = 1'b1;

    typedef enum logic [2:0] {
        T_IDLE,
        T_ROUND,
        T_SMUL,
        T_SDIV,
        T_SQR,
        T_PREP,
        T_QUO,
        T_DONE
    } tanh_state_t;

endpackage

>>> hdl/ndpt_ram.sv
// Generic single-port RAM with a registered read port.
// Self-contained; holds the weight store of the neuron core.
module ndpt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/neuron_dot_product_tanh_core.sv
// Top level of the single-neuron core: weight store, multiply-accumulate
// pipeline and a sequenced fixed-point tanh unit. Uses ndpt_pkg and ndpt_ram.
//
//  channel  | handshake          | carries
//  ---------+--------------------+------------------------------------------
//  input    | s_valid / s_ready  | s_req_type, s_index, s_value, s_last
//  result   | m_valid / m_ready  | m_activation, m_clipped_sum, m_length_error
//  config   | cfg_wr_en          | cfg_wr_data (n_inputs)
//
// Weight writes and data elements are taken one per cycle while s_ready is
// high; a data element passes a weight read, a multiply and an accumulate
// stage. After a last element the tanh unit rounds the sum, then computes
// twelve series terms, each a multiply (four 32x32 partial products and a
// final add) followed by a bit-serial division by the term index, then nine
// squarings, a set-up step, a 16-bit quotient and a load of the output. A
// length error skips it. Input is refused from a last element until its
// result is held in the output register; a stalled result holds while
// m_ready is low. Reset is synchronous; the weight store is not cleared by
// it.
module neuron_dot_product_tanh_core
    import ndpt_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CNT_W-1:0]        cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_req_type,
    input  logic [IDX_W-1:0]        s_index,
    input  logic signed [VAL_W-1:0] s_value,
    input  logic                    s_last,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [VAL_W-1:0] m_activation,
    output logic signed [VAL_W-1:0] m_clipped_sum,
    output logic                    m_length_error
);

    logic [CNT_W-1:0] n_inputs_reg;

    // Input pipeline
    logic                    accept;
    logic                    idx_in_range;
    logic [VAL_W-1:0]        ram_rdata;
    logic                    st1_valid_reg, st1_last_reg, st1_inr_reg;
    logic signed [VAL_W-1:0] st1_val_reg;
    logic signed [VAL_W-1:0] weight;
    logic                    st2_valid_reg, st2_last_reg;
    logic signed [PROD_W-1:0] st2_prod_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_sat;
    logic [ACC_W:0]          acc_sum;
    logic [CNT_W-1:0]        count_reg, count_inc;
    logic [ACC_W-1:0]        fin_acc_reg;
    logic [CNT_W-1:0]        fin_cnt_reg;

    // Rounding of the final sum
    logic [ACC_W:0]          rnd;
    logic [VAL_W-1:0]        sum_w;
    logic [VAL_W-1:0]        mag_w;
    logic                    err_w;

    // Tanh sequencer
    tanh_state_t             state_reg, state_next;
    logic [STEP_W-1:0]       step_reg;
    logic [KCNT_W-1:0]       k_reg, sq_reg;
    logic [VAL_W-1:0]        sum_reg;
    logic                    err_reg, neg_reg;
    logic [U_W-1:0]          u_reg;
    logic [FX_W-1:0]         term_reg, e_reg;
    logic [FX_W-1:0]         mul_a, mul_b;
    logic [HALF_W-1:0]       a_part, b_part;
    logic [2*HALF_W-1:0]     pp_next, pp_reg;
    logic [1:0]              sh_reg;
    logic [MP_W-1:0]         pp_shift, prod_acc_reg, prod_sum;
    logic [FX_W-1:0]         dq_reg, dq_next;
    logic [KCNT_W-1:0]       rem_reg, rem_next;
    logic [KCNT_W:0]         rem_t;
    logic                    div_ge;
    logic [FX_W:0]           r_reg, den_reg;
    logic [FX_W+1:0]         r2;
    logic                    quo_ge;
    logic [QUO_W-1:0]        q_reg;
    logic [QUO_W:0]          res_w;
    logic [VAL_W-1:0]        act_w;
    logic                    out_free, out_load;

    logic                    m_valid_reg, m_length_error_reg;
    logic [VAL_W-1:0]        m_activation_reg, m_clipped_sum_reg;

    // ------------------------------------------------------------------
    // Configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_inputs_reg <= CNT_W'(1);
        end else if (cfg_wr_en) begin
            n_inputs_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Weight store and multiply-accumulate pipeline
    assign s_ready = (state_reg == T_IDLE) && !(st1_valid_reg && st1_last_reg)
                     && !(st2_valid_reg && st2_last_reg);
    assign accept       = s_valid && s_ready;
    assign idx_in_range = (32'(s_index) < MAX_INPUTS);

    ndpt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_INPUTS)
    ) u_weight_ram (
        .aclk  (aclk),
        .we    (accept && (s_req_type == REQ_WEIGHT) && idx_in_range),
        .addr  (WADDR_W'(s_index)),
        .wdata (s_value),
        .rdata (ram_rdata)
    );

    // An element beyond the store is multiplied by zero.
    assign weight = st1_inr_reg ? signed'(ram_rdata) : '0;

    always_comb begin
        acc_sum = {acc_reg[ACC_W-1], acc_reg}
                  + {{(ACC_W + 1 - PROD_W){st2_prod_reg[PROD_W-1]}}, st2_prod_reg};
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
            acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                     : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
        count_inc = (count_reg == {CNT_W{1'b1}}) ? count_reg : count_reg + CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            acc_reg       <= '0;
            count_reg     <= '0;
        end else begin
            st1_valid_reg <= accept && (s_req_type == REQ_DATA);
            st2_valid_reg <= st1_valid_reg;
            if (st2_valid_reg) begin
                if (st2_last_reg) begin
                    acc_reg   <= '0;
                    count_reg <= '0;
                end else begin
                    acc_reg   <= acc_sat;
                    count_reg <= count_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        st1_last_reg <= s_last;
        st1_inr_reg  <= idx_in_range;
        st1_val_reg  <= s_value;
        st2_last_reg <= st1_last_reg;
        st2_prod_reg <= st1_val_reg * weight;
        if (st2_valid_reg && st2_last_reg) begin
            fin_acc_reg <= acc_sat;
            fin_cnt_reg <= count_inc;
        end
    end

    // ------------------------------------------------------------------
    // Round half up and saturate the Q24.24 sum to Q4.12.
    always_comb begin
        rnd = {fin_acc_reg[ACC_W-1], fin_acc_reg} + (ACC_W + 1)'(2048);
        if (!rnd[ACC_W] && (|rnd[ACC_W-1:27])) begin
            sum_w = {1'b0, {(VAL_W-1){1'b1}}};
        end else if (rnd[ACC_W] && !(&rnd[ACC_W-1:27])) begin
            sum_w = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            sum_w = rnd[27:12];
        end
        mag_w = sum_w[VAL_W-1] ? (VAL_W'(0) - sum_w) : sum_w;
        err_w = (fin_cnt_reg != n_inputs_reg);
    end

    // ------------------------------------------------------------------
    // Shared multiplier: a 61x61 product built from four 32x32 partial
    // products, each registered and then added into the wide accumulator.
    always_comb begin
        mul_a  = (state_reg == T_SQR) ? e_reg : term_reg;
        mul_b  = (state_reg == T_SQR) ? e_reg : FX_W'(u_reg);
        a_part = step_reg[1] ? HALF_W'(mul_a >> HALF_W) : mul_a[HALF_W-1:0];
        b_part = step_reg[0] ? HALF_W'(mul_b >> HALF_W) : mul_b[HALF_W-1:0];
        pp_next = {{HALF_W{1'b0}}, a_part} * {{HALF_W{1'b0}}, b_part};
        case (sh_reg) inside
            2'd0:       pp_shift = MP_W'(pp_reg);
            2'd1, 2'd2: pp_shift = MP_W'(pp_reg) << HALF_W;
            default:    pp_shift = MP_W'(pp_reg) << (2 * HALF_W);
        endcase
        prod_sum = prod_acc_reg + pp_shift;
    end

    // Bit-serial division by the series index, one quotient bit a cycle.
    always_comb begin
        rem_t    = {rem_reg, dq_reg[FX_W-1]};
        div_ge   = (rem_t >= {1'b0, k_reg});
        rem_next = div_ge ? KCNT_W'(rem_t - {1'b0, k_reg}) : rem_t[KCNT_W-1:0];
        dq_next  = {dq_reg[FX_W-2:0], div_ge};
    end

    // Restoring division (1 - e) / (1 + e), one bit a cycle.
    always_comb begin
        r2     = {r_reg, 1'b0};
        quo_ge = (r2 >= {1'b0, den_reg});
    end

    always_comb begin
        res_w = ((QUO_W + 1)'(q_reg) + (QUO_W + 1)'(1)) >> 1;
        if (err_reg) begin
            act_w = '0;
        end else if (neg_reg) begin
            act_w = VAL_W'(0) - res_w[VAL_W-1:0];
        end else if (res_w > (QUO_W + 1)'(32767)) begin
            act_w = {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
            act_w = res_w[VAL_W-1:0];
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == T_DONE) && out_free;

    // ------------------------------------------------------------------
    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE: begin
                if (st2_valid_reg && st2_last_reg) begin
                    state_next = T_ROUND;
                end
            end
            T_ROUND: begin
                state_next = err_w ? T_DONE : T_SMUL;
            end
            T_SMUL: begin
                if (step_reg == STEP_W'(MUL_LAST)) begin
                    state_next = T_SDIV;
                end
            end
            T_SDIV: begin
                if (step_reg == STEP_W'(DIV_LAST)) begin
                    state_next = (k_reg == KCNT_W'(N_TERMS)) ? T_SQR : T_SMUL;
                end
            end
            T_SQR: begin
                if (step_reg == STEP_W'(MUL_LAST) && sq_reg == KCNT_W'(N_SQUARES - 1)) begin
                    state_next = T_PREP;
                end
            end
            T_PREP: begin
                state_next = T_QUO;
            end
            T_QUO: begin
                if (step_reg == STEP_W'(QUO_LAST)) begin
                    state_next = T_DONE;
                end
            end
            T_DONE: begin
                if (out_free) begin
                    state_next = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    // Step, term index and squaring counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            k_reg    <= KCNT_W'(1);
            sq_reg   <= '0;
        end else begin
            if (state_next != state_reg) begin
                step_reg <= '0;
            end else if (state_reg == T_SQR && step_reg == STEP_W'(MUL_LAST)) begin
                step_reg <= '0;
            end else if (state_reg != T_IDLE && state_reg != T_DONE) begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (state_reg == T_ROUND) begin
                k_reg  <= KCNT_W'(1);
                sq_reg <= '0;
            end else if (state_reg == T_SDIV && step_reg == STEP_W'(DIV_LAST)) begin
                k_reg <= k_reg + KCNT_W'(1);
            end else if (state_reg == T_SQR && step_reg == STEP_W'(MUL_LAST)) begin
                sq_reg <= sq_reg + KCNT_W'(1);
            end
        end
    end

    // Tanh datapath
    always_ff @(posedge aclk) begin
        if (state_reg == T_SMUL || state_reg == T_SQR) begin
            pp_reg       <= pp_next;
            sh_reg       <= step_reg[1:0];
            prod_acc_reg <= (step_reg == '0) ? '0 : prod_sum;
        end
        unique case (state_reg)
            T_ROUND: begin
                sum_reg  <= sum_w;
                err_reg  <= err_w;
                neg_reg  <= sum_w[VAL_W-1];
                u_reg    <= U_W'(mag_w) << (U_W - VAL_W);
                term_reg <= Q60_ONE;
                e_reg    <= Q60_ONE;
            end
            T_SMUL: begin
                if (step_reg == STEP_W'(MUL_LAST)) begin
                    dq_reg  <= prod_sum[FRAC+FX_W-1:FRAC];
                    rem_reg <= '0;
                end
            end
            T_SDIV: begin
                dq_reg  <= dq_next;
                rem_reg <= rem_next;
                if (step_reg == STEP_W'(DIV_LAST)) begin
                    term_reg <= dq_next;
                    // Odd terms of the series for e^-u are subtracted.
                    e_reg    <= k_reg[0] ? (e_reg - dq_next) : (e_reg + dq_next);
                end
            end
            T_SQR: begin
                if (step_reg == STEP_W'(MUL_LAST)) begin
                    e_reg <= prod_sum[FRAC+FX_W-1:FRAC];
                end
            end
            T_PREP: begin
                r_reg   <= {1'b0, Q60_ONE - e_reg};
                den_reg <= {1'b0, Q60_ONE} + {1'b0, e_reg};
                q_reg   <= '0;
            end
            T_QUO: begin
                r_reg <= quo_ge ? (FX_W + 1)'(r2 - {1'b0, den_reg}) : r2[FX_W:0];
                q_reg <= {q_reg[QUO_W-2:0], quo_ge};
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_activation_reg   <= act_w;
            m_clipped_sum_reg  <= sum_reg;
            m_length_error_reg <= err_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_activation   = signed'(m_activation_reg);
    assign m_clipped_sum  = signed'(m_clipped_sum_reg);
    assign m_length_error = m_length_error_reg;

    // ------------------------------------------------------------------
    // Assertions
    a_acc_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        st2_valid_reg && st2_last_reg |=> (acc_reg == '0) && (count_reg == '0))
        else $error("accumulator not cleared after the last element");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == T_DONE))
        else $error("result presented outside the done state");

    a_last_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_valid_reg && st1_last_reg) || (state_reg != T_IDLE) |-> !s_ready)
        else $error("input taken while an evaluation is finishing");

    a_term_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_SDIV) |-> (k_reg >= KCNT_W'(1)) && (k_reg <= KCNT_W'(N_TERMS)))
        else $error("series term index out of range");

endmodule
